[rtl/egf_pkg.sv]
`default_nettype none
package egf_pkg;

    localparam int FEAT_W      = 24;
    localparam int IDX_W       = 5;
    localparam int MAX_CENTERS = 32;
    localparam int GRID_FIRST  = 3;
    localparam int GRID_STEP   = 8;
    localparam int GRAD_W      = 8;

    localparam logic [FEAT_W-1:0] FEAT_MAX = {FEAT_W{1'b1}};
    localparam logic [16:0] SQRT2_Q16 = 17'd92682;

    localparam logic [63:0] Q31_ONE   = 64'd2147483648;
    localparam logic [63:0] Q31_DECAY = 64'd2066211038;
    localparam logic [63:0] Q31_NORM  = 64'd26372117;

    typedef struct packed {
        logic mode;
    } job_t;

    typedef struct packed {
        logic grad_busy;
    } back_status_t;

endpackage
`default_nettype wire

[rtl/egf_ram.sv]
`default_nettype none
module egf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

[rtl/egf_job_fifo.sv]
`default_nettype none
module egf_job_fifo
    import egf_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire job_t push_job,
    input  wire logic pop,
    output logic      not_empty,
    output job_t      head_job
);

    job_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign not_empty = (count_reg != 2'd0);
    assign head_job  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= 1'b0;
            rd_ptr_reg   <= 1'b0;
            count_reg    <= 2'd0;
            entry_reg[0] <= '0;
            entry_reg[1] <= '0;
        end
        else
        begin
            if (push && count_reg != 2'd2)
            begin
                entry_reg[wr_ptr_reg] <= push_job;
                wr_ptr_reg            <= ~wr_ptr_reg;
            end
            if (pop && not_empty)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if ((push && count_reg != 2'd2) && !(pop && not_empty))
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (!(push && count_reg != 2'd2) && (pop && not_empty))
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule
`default_nettype wire

[rtl/egf_front.sv]
`default_nettype none
module egf_front
    import egf_pkg::*;
#(
    parameter int PATCH_ROWS = 64,
    parameter int PATCH_COLS = 32
) (
    input  wire logic                                        clk,
    input  wire logic                                        rst_n,
    input  wire logic                                        cfg_we,
    input  wire logic                                        cfg_patch_mode,
    input  wire logic                                        in_valid,
    output logic                                             in_stall,
    input  wire logic [7:0]                                  pixel,
    output logic                                             pix_we,
    output logic [$clog2(PATCH_ROWS*PATCH_COLS)-1:0]         pix_addr,
    output logic [7:0]                                       pix_data,
    output logic                                             job_push,
    output job_t                                             job,
    input  wire logic                                        queue_not_empty,
    input  wire back_status_t                                back_status
);

    localparam int AW = $clog2(PATCH_ROWS * PATCH_COLS);
    localparam logic [AW-1:0] LAST_FULL = AW'(PATCH_ROWS * PATCH_COLS - 1);
    localparam logic [AW-1:0] LAST_HALF = AW'((PATCH_ROWS / 2) * PATCH_COLS - 1);

    logic          mode_reg;
    logic [AW-1:0] load_count_reg;
    logic          accept;
    logic          last_pixel;

    // The pixel store is shared with the gradient pass, so loading waits for it.
    assign in_stall   = queue_not_empty || back_status.grad_busy;
    assign accept     = in_valid && !in_stall;
    assign last_pixel = (load_count_reg == (mode_reg ? LAST_HALF : LAST_FULL));

    assign pix_we   = accept;
    assign pix_addr = load_count_reg;
    assign pix_data = pixel;
    assign job_push = accept && last_pixel;
    assign job.mode = mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= 1'b0;
            load_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            mode_reg       <= cfg_patch_mode;
            load_count_reg <= '0;
        end
        else if (accept)
        begin
            load_count_reg <= last_pixel ? '0 : load_count_reg + AW'(1);
        end
    end

endmodule
`default_nettype wire

[rtl/egf_back.sv]
`default_nettype none
module egf_back
    import egf_pkg::*;
#(
    parameter int PATCH_ROWS  = 64,
    parameter int PATCH_COLS  = 32,
    parameter int WINDOW_SIZE = 32,
    parameter int WEIGHT_BITS = 16
) (
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    input  wire logic                                      job_valid,
    input  wire job_t                                      job,
    output logic                                           job_pop,
    output back_status_t                                   status,
    output logic                                           pix_rd_en,
    output logic [$clog2(PATCH_ROWS*PATCH_COLS)-1:0]       pix_rd_addr,
    input  wire logic [7:0]                                pix_rd_data,
    output logic                                           grd_we,
    output logic [$clog2(PATCH_ROWS*PATCH_COLS)-1:0]       grd_wr_addr,
    output logic [2*GRAD_W-1:0]                            grd_wr_data,
    output logic                                           grd_rd_en,
    output logic [$clog2(PATCH_ROWS*PATCH_COLS)-1:0]       grd_rd_addr,
    input  wire logic [2*GRAD_W-1:0]                       grd_rd_data,
    output logic                                           out_valid,
    input  wire logic                                      out_stall,
    output logic [FEAT_W-1:0]                              out_axis [4],
    output logic [FEAT_W-1:0]                              out_diag [4],
    output logic [IDX_W-1:0]                               out_index,
    output logic                                           out_last
);

    localparam int AW    = $clog2(PATCH_ROWS * PATCH_COLS);
    localparam int RW    = $clog2(PATCH_ROWS);
    localparam int CLW   = $clog2(PATCH_COLS);
    localparam int WB    = WEIGHT_BITS;
    localparam int HALF  = WINDOW_SIZE / 2;
    localparam int NW    = (HALF + 1) * (HALF + 1);
    localparam int RIW   = $clog2(NW);
    localparam int WINW  = $clog2(WINDOW_SIZE);
    localparam int KW    = $clog2(PATCH_ROWS + PATCH_COLS + WINDOW_SIZE) + 1;
    localparam int ACC_W = WB + 8;
    localparam int PW    = WB + 7;
    localparam int TW    = ACC_W + 18;
    localparam int AX_RS  = (WB > 16) ? WB - 16 : 0;
    localparam int AX_LS  = (WB > 16) ? 0 : 16 - WB;
    localparam logic [TW-1:0] AX_RND = (WB > 16) ? (TW'(1) << (WB - 17)) : '0;
    localparam logic [TW-1:0] DG_RND = TW'(1) << (WB - 1);

    typedef logic [WB-1:0] wrom_t [NW];

    function automatic wrom_t build_weights();
        wrom_t       tab;
        logic [63:0] g [HALF+1];
        logic [63:0] p;
        logic [63:0] t;
        logic [63:0] prod;
        int          n;
        p = Q31_ONE;
        n = 0;
        for (int d = 0; d <= HALF; d++)
        begin
            while (n < d * d)
            begin
                p = (p * Q31_DECAY) >> 31;
                n++;
            end
            g[d] = p;
        end
        for (int da = 0; da <= HALF; da++)
        begin
            for (int db = 0; db <= HALF; db++)
            begin
                t    = (g[da] * g[db]) >> 31;
                prod = t * Q31_NORM;
                tab[da*(HALF+1)+db] = WB'((prod + (64'd1 << (61 - WB))) >> (62 - WB));
            end
        end
        return tab;
    endfunction

    localparam wrom_t WROM = build_weights();

    function automatic logic [FEAT_W-1:0] sat(input logic [TW-1:0] v);
        return (v > TW'(FEAT_MAX)) ? FEAT_MAX : v[FEAT_W-1:0];
    endfunction

    typedef enum logic [2:0] {
        ST_IDLE, ST_G_RD, ST_G_WAIT, ST_G_WR, ST_P_TAP, ST_P_DRAIN, ST_FIN, ST_EMIT
    } state_t;

    state_t             state_reg;
    logic               mode_reg;
    logic [RW-1:0]      row_reg;
    logic [CLW-1:0]     col_reg;
    logic [1:0]         tr_reg, tc_reg, tr_d_reg, tc_d_reg;
    logic               rd_vld_reg;
    logic signed [11:0] sx_reg, sy_reg;
    logic [KW-1:0]      ci_reg, cj_reg;
    logic [WINW-1:0]    a_reg, b_reg;
    logic [IDX_W-1:0]   count_reg;
    logic               drain_reg;
    logic [1:0]         fin_reg;
    logic               v1_reg, v2_reg;
    logic [WB-1:0]      w1_reg;
    logic [PW-1:0]      pa_reg, pd_reg;
    logic [1:0]         asel_reg, dsel_reg;
    logic [ACC_W-1:0]   acc_axis_reg [4];
    logic [ACC_W-1:0]   acc_diag_reg [4];
    logic [FEAT_W-1:0]  stage_axis_reg [4];
    logic [FEAT_W-1:0]  stage_diag_reg [4];
    logic [FEAT_W-1:0]  out_axis_reg [4];
    logic [FEAT_W-1:0]  out_diag_reg [4];
    logic [IDX_W-1:0]   out_index_reg;
    logic               out_last_reg;
    logic               out_valid_reg;

    // Gradient pass
    logic [RW-1:0]      prow;
    logic [CLW-1:0]     pcol;
    logic signed [11:0] pv, sx_term, sy_term;
    logic signed [11:0] sx_q, sy_q;
    logic               row_last, col_last;

    assign prow      = row_reg + RW'(tr_reg) - RW'(1);
    assign pcol      = col_reg + CLW'(tc_reg) - CLW'(1);
    assign pix_rd_en   = (state_reg == ST_G_RD);
    assign pix_rd_addr = AW'(int'(prow) * PATCH_COLS + int'(pcol));

    assign pv = $signed({4'b0000, pix_rd_data});

    always_comb
    begin
        case (tr_d_reg)
            2'd0:    sx_term = (tc_d_reg == 2'd1) ? -(pv <<< 1) : -pv;
            2'd2:    sx_term = (tc_d_reg == 2'd1) ?  (pv <<< 1) :  pv;
            default: sx_term = '0;
        endcase
        case (tc_d_reg)
            2'd0:    sy_term = (tr_d_reg == 2'd1) ? -(pv <<< 1) : -pv;
            2'd2:    sy_term = (tr_d_reg == 2'd1) ?  (pv <<< 1) :  pv;
            default: sy_term = '0;
        endcase
    end

    // Division by eight truncating toward zero.
    assign sx_q = (sx_reg < 0) ? ((sx_reg + 12'sd7) >>> 3) : (sx_reg >>> 3);
    assign sy_q = (sy_reg < 0) ? ((sy_reg + 12'sd7) >>> 3) : (sy_reg >>> 3);

    assign grd_we      = (state_reg == ST_G_WR);
    assign grd_wr_addr = AW'(int'(row_reg) * PATCH_COLS + int'(col_reg));
    assign grd_wr_data = {sx_q[GRAD_W-1:0], sy_q[GRAD_W-1:0]};

    assign row_last = (row_reg == (mode_reg ? RW'(PATCH_ROWS / 2 - 2) : RW'(PATCH_ROWS - 2)));
    assign col_last = (col_reg == CLW'(PATCH_COLS - 2));

    // Pooling pass
    logic [KW-1:0]   h_v, rows_v, s_k, s_l;
    logic [WINW-1:0] win_last, da, db, hw;
    logic            in_k, in_l;
    logic [31:0]     ridx;
    logic            tap_last, center_last;

    assign hw       = mode_reg ? WINW'(HALF / 2) : WINW'(HALF);
    assign h_v      = KW'(hw);
    assign rows_v   = mode_reg ? KW'(PATCH_ROWS / 2) : KW'(PATCH_ROWS);
    assign win_last = mode_reg ? WINW'(HALF - 1) : WINW'(WINDOW_SIZE - 1);
    assign s_k      = ci_reg + KW'(a_reg);
    assign s_l      = cj_reg + KW'(b_reg);
    assign in_k     = (s_k >= h_v + KW'(1)) && (s_k <= h_v + rows_v - KW'(2));
    assign in_l     = (s_l >= h_v + KW'(1)) && (s_l <= h_v + KW'(PATCH_COLS - 2));
    assign da       = (a_reg < hw) ? hw - a_reg : a_reg - hw;
    assign db       = (b_reg < hw) ? hw - b_reg : b_reg - hw;
    assign ridx     = 32'(da) * 32'(HALF + 1) + 32'(db);
    assign tap_last = (a_reg == win_last) && (b_reg == win_last);

    assign grd_rd_en   = (state_reg == ST_P_TAP) && in_k && in_l;
    assign grd_rd_addr = AW'(int'(s_k - h_v) * PATCH_COLS + int'(s_l - h_v));

    assign center_last = (count_reg == IDX_W'(MAX_CENTERS - 1)) ||
                         ((cj_reg + KW'(GRID_STEP) >= KW'(PATCH_COLS)) &&
                          (ci_reg + KW'(GRID_STEP) >= rows_v));

    logic signed [GRAD_W-1:0] gx, gy;
    logic [GRAD_W-1:0]        ax, ay, axis_m, diag_m;

    assign gx     = $signed(grd_rd_data[2*GRAD_W-1:GRAD_W]);
    assign gy     = $signed(grd_rd_data[GRAD_W-1:0]);
    assign ax     = (gx < 0) ? GRAD_W'(-gx) : GRAD_W'(gx);
    assign ay     = (gy < 0) ? GRAD_W'(-gy) : GRAD_W'(gy);
    assign axis_m = (ax > ay) ? ax - ay : ay - ax;
    assign diag_m = (ax < ay) ? ax : ay;

    logic [TW-1:0] ax_conv, dg_conv;

    assign ax_conv = ((TW'(acc_axis_reg[fin_reg]) << AX_LS) + AX_RND) >> AX_RS;
    assign dg_conv = (TW'(acc_diag_reg[fin_reg]) * TW'(SQRT2_Q16) + DG_RND) >> WB;

    assign job_pop          = (state_reg == ST_IDLE) && job_valid;
    assign status.grad_busy = (state_reg == ST_G_RD) || (state_reg == ST_G_WAIT) ||
                              (state_reg == ST_G_WR);

    assign out_valid = out_valid_reg;
    assign out_index = out_index_reg;
    assign out_last  = out_last_reg;
    assign out_axis  = out_axis_reg;
    assign out_diag  = out_diag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= 1'b0;
            row_reg       <= '0;
            col_reg       <= '0;
            tr_reg        <= '0;
            tc_reg        <= '0;
            tr_d_reg      <= '0;
            tc_d_reg      <= '0;
            rd_vld_reg    <= 1'b0;
            sx_reg        <= '0;
            sy_reg        <= '0;
            ci_reg        <= '0;
            cj_reg        <= '0;
            a_reg         <= '0;
            b_reg         <= '0;
            count_reg     <= '0;
            drain_reg     <= 1'b0;
            fin_reg       <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            w1_reg        <= '0;
            pa_reg        <= '0;
            pd_reg        <= '0;
            asel_reg      <= '0;
            dsel_reg      <= '0;
            out_index_reg <= '0;
            out_last_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                acc_axis_reg[i]   <= '0;
                acc_diag_reg[i]   <= '0;
                stage_axis_reg[i] <= '0;
                stage_diag_reg[i] <= '0;
                out_axis_reg[i]   <= '0;
                out_diag_reg[i]   <= '0;
            end
        end
        else
        begin
            rd_vld_reg <= (state_reg == ST_G_RD);
            tr_d_reg   <= tr_reg;
            tc_d_reg   <= tc_reg;
            if (rd_vld_reg)
            begin
                sx_reg <= sx_reg + sx_term;
                sy_reg <= sy_reg + sy_term;
            end

            // Tap pipeline: address, then weight and gradient, then products.
            v1_reg <= grd_rd_en;
            w1_reg <= WROM[ridx[RIW-1:0]];
            v2_reg <= v1_reg;
            pa_reg <= PW'(w1_reg) * PW'(axis_m);
            pd_reg <= PW'(w1_reg) * PW'(diag_m);
            if (ay <= ax)
            begin
                asel_reg <= (gx >= 0) ? 2'd3 : 2'd1;
            end
            else
            begin
                asel_reg <= (gy >= 0) ? 2'd2 : 2'd0;
            end
            if (gx >= 0)
            begin
                dsel_reg <= (gy >= 0) ? 2'd2 : 2'd3;
            end
            else
            begin
                dsel_reg <= (gy < 0) ? 2'd0 : 2'd1;
            end
            if (v2_reg)
            begin
                acc_axis_reg[asel_reg] <= acc_axis_reg[asel_reg] + ACC_W'(pa_reg);
                acc_diag_reg[dsel_reg] <= acc_diag_reg[dsel_reg] + ACC_W'(pd_reg);
            end

            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (job_valid)
                    begin
                        mode_reg  <= job.mode;
                        row_reg   <= RW'(1);
                        col_reg   <= CLW'(1);
                        tr_reg    <= '0;
                        tc_reg    <= '0;
                        sx_reg    <= '0;
                        sy_reg    <= '0;
                        state_reg <= ST_G_RD;
                    end
                end
                ST_G_RD:
                begin
                    if (tc_reg == 2'd2)
                    begin
                        tc_reg <= '0;
                        tr_reg <= tr_reg + 2'd1;
                        if (tr_reg == 2'd2)
                        begin
                            state_reg <= ST_G_WAIT;
                        end
                    end
                    else
                    begin
                        tc_reg <= tc_reg + 2'd1;
                    end
                end
                ST_G_WAIT:
                begin
                    state_reg <= ST_G_WR;
                end
                ST_G_WR:
                begin
                    sx_reg <= '0;
                    sy_reg <= '0;
                    tr_reg <= '0;
                    tc_reg <= '0;
                    if (col_last)
                    begin
                        col_reg <= CLW'(1);
                        row_reg <= row_reg + RW'(1);
                    end
                    else
                    begin
                        col_reg <= col_reg + CLW'(1);
                    end
                    if (col_last && row_last)
                    begin
                        ci_reg    <= KW'(GRID_FIRST);
                        cj_reg    <= KW'(GRID_FIRST);
                        count_reg <= '0;
                        a_reg     <= '0;
                        b_reg     <= '0;
                        for (int i = 0; i < 4; i++)
                        begin
                            acc_axis_reg[i] <= '0;
                            acc_diag_reg[i] <= '0;
                        end
                        state_reg <= ST_P_TAP;
                    end
                    else
                    begin
                        state_reg <= ST_G_RD;
                    end
                end
                ST_P_TAP:
                begin
                    if (b_reg == win_last)
                    begin
                        b_reg <= '0;
                        a_reg <= a_reg + WINW'(1);
                    end
                    else
                    begin
                        b_reg <= b_reg + WINW'(1);
                    end
                    if (tap_last)
                    begin
                        drain_reg <= 1'b0;
                        state_reg <= ST_P_DRAIN;
                    end
                end
                ST_P_DRAIN:
                begin
                    drain_reg <= 1'b1;
                    if (drain_reg)
                    begin
                        fin_reg   <= '0;
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    stage_axis_reg[fin_reg] <= sat(ax_conv);
                    stage_diag_reg[fin_reg] <= sat(dg_conv);
                    fin_reg <= fin_reg + 2'd1;
                    if (fin_reg == 2'd3)
                    begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_axis_reg  <= stage_axis_reg;
                        out_diag_reg  <= stage_diag_reg;
                        out_index_reg <= count_reg;
                        out_last_reg  <= center_last;
                        out_valid_reg <= 1'b1;
                        a_reg         <= '0;
                        b_reg         <= '0;
                        for (int i = 0; i < 4; i++)
                        begin
                            acc_axis_reg[i] <= '0;
                            acc_diag_reg[i] <= '0;
                        end
                        count_reg <= count_reg + IDX_W'(1);
                        if (cj_reg + KW'(GRID_STEP) >= KW'(PATCH_COLS))
                        begin
                            cj_reg <= KW'(GRID_FIRST);
                            ci_reg <= ci_reg + KW'(GRID_STEP);
                        end
                        else
                        begin
                            cj_reg <= cj_reg + KW'(GRID_STEP);
                        end
                        state_reg <= center_last ? ST_IDLE : ST_P_TAP;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

[rtl/eight_direction_gradient_features_core.sv]
// Eight-direction gradient feature core.
// Pixels of one grayscale patch enter in raster order on the in channel (in_valid,
// in_stall, pixel). Once the last pixel of the patch is in, the core computes the
// gradients of all interior pixels and then pools one window per grid center,
// emitting one item per center on the out channel, in raster order of centers, with
// last_center set on the final one. cfg_we writes patch_mode and restarts the load.
// A patch of R rows and C columns is loaded first; the gradient pass then makes nine
// reads of the single pixel-store port per interior pixel, during which in_stall is
// high. Each center is then pooled at one window tap per cycle through the gradient
// store; the next patch may load while centers are being pooled.
// A result waits in the output register while out_stall is high; pooling of the next
// center continues and holds only when its own result is ready.
// Reset clears the load position, patch_mode and all control; no clearing pass.
`default_nettype none
module eight_direction_gradient_features_core
    import egf_pkg::*;
#(
    parameter int PATCH_ROWS  = 64,
    parameter int PATCH_COLS  = 32,
    parameter int WINDOW_SIZE = 32,
    parameter int WEIGHT_BITS = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic              cfg_patch_mode,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [7:0]        pixel,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [FEAT_W-1:0]      feat_d1,
    output logic [FEAT_W-1:0]      feat_d2,
    output logic [FEAT_W-1:0]      feat_d3,
    output logic [FEAT_W-1:0]      feat_d4,
    output logic [FEAT_W-1:0]      feat_d5,
    output logic [FEAT_W-1:0]      feat_d6,
    output logic [FEAT_W-1:0]      feat_d7,
    output logic [FEAT_W-1:0]      feat_d8,
    output logic [IDX_W-1:0]       center_index,
    output logic                   last_center
);

    localparam int DEPTH = PATCH_ROWS * PATCH_COLS;
    localparam int AW    = $clog2(DEPTH);

    logic              pix_we, pix_rd_en;
    logic [AW-1:0]     pix_addr, pix_rd_addr;
    logic [7:0]        pix_data, pix_rd_data;
    logic              grd_we, grd_rd_en;
    logic [AW-1:0]     grd_wr_addr, grd_rd_addr;
    logic [2*GRAD_W-1:0] grd_wr_data, grd_rd_data;
    logic              job_push, job_pop, queue_not_empty;
    job_t              job_in, job_head;
    back_status_t      back_status;
    logic [FEAT_W-1:0] out_axis [4];
    logic [FEAT_W-1:0] out_diag [4];

    egf_front #(
        .PATCH_ROWS (PATCH_ROWS),
        .PATCH_COLS (PATCH_COLS)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_patch_mode  (cfg_patch_mode),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .pixel           (pixel),
        .pix_we          (pix_we),
        .pix_addr        (pix_addr),
        .pix_data        (pix_data),
        .job_push        (job_push),
        .job             (job_in),
        .queue_not_empty (queue_not_empty),
        .back_status     (back_status)
    );

    egf_job_fifo u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_job  (job_in),
        .pop       (job_pop),
        .not_empty (queue_not_empty),
        .head_job  (job_head)
    );

    egf_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_pixel_ram (
        .clk     (clk),
        .wr_en   (pix_we),
        .wr_addr (pix_addr),
        .wr_data (pix_data),
        .rd_en   (pix_rd_en),
        .rd_addr (pix_rd_addr),
        .rd_data (pix_rd_data)
    );

    egf_ram #(
        .WIDTH (2 * GRAD_W),
        .DEPTH (DEPTH)
    ) u_grad_ram (
        .clk     (clk),
        .wr_en   (grd_we),
        .wr_addr (grd_wr_addr),
        .wr_data (grd_wr_data),
        .rd_en   (grd_rd_en),
        .rd_addr (grd_rd_addr),
        .rd_data (grd_rd_data)
    );

    egf_back #(
        .PATCH_ROWS  (PATCH_ROWS),
        .PATCH_COLS  (PATCH_COLS),
        .WINDOW_SIZE (WINDOW_SIZE),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (queue_not_empty),
        .job         (job_head),
        .job_pop     (job_pop),
        .status      (back_status),
        .pix_rd_en   (pix_rd_en),
        .pix_rd_addr (pix_rd_addr),
        .pix_rd_data (pix_rd_data),
        .grd_we      (grd_we),
        .grd_wr_addr (grd_wr_addr),
        .grd_wr_data (grd_wr_data),
        .grd_rd_en   (grd_rd_en),
        .grd_rd_addr (grd_rd_addr),
        .grd_rd_data (grd_rd_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_axis    (out_axis),
        .out_diag    (out_diag),
        .out_index   (center_index),
        .out_last    (last_center)
    );

    assign feat_d1 = out_axis[0];
    assign feat_d3 = out_axis[1];
    assign feat_d5 = out_axis[2];
    assign feat_d7 = out_axis[3];
    assign feat_d2 = out_diag[0];
    assign feat_d4 = out_diag[1];
    assign feat_d6 = out_diag[2];
    assign feat_d8 = out_diag[3];

endmodule
`default_nettype wire
